// ===== hdl/usqs_pkg.sv =====
// shared types, constants and helper functions for the uplink slot queue scheduler
`default_nettype none
package usqs_pkg;

    localparam int QUEUE_SLOTS = 32;
    localparam int PTR_W       = $clog2(QUEUE_SLOTS);
    localparam int LVL_W       = 5;
    localparam int REF_W       = 16;
    localparam int CLS_W       = 2;
    localparam int ENTRY_W     = CLS_W + REF_W;
    localparam int TIME_W      = 32;
    localparam int ID_W        = 24;
    localparam int CMD_W       = 16;
    localparam int DROP_W      = 16;
    localparam int REP_W       = 3;
    localparam int WIN_W       = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int SRC_W       = 2;
    localparam int IN_DATA_W   = 88;
    localparam int OUT_DATA_W  = 40;

    typedef logic [PTR_W-1:0] ptr_t;

    localparam logic [ID_W-1:0] ID_HEARTBEAT = 24'd0;
    localparam logic [ID_W-1:0] ID_SET_MODE  = 24'd11;
    localparam logic [ID_W-1:0] ID_MANUAL    = 24'd69;
    localparam logic [ID_W-1:0] ID_LONG      = 24'd76;

    localparam logic [CMD_W-1:0] CMD_ARM      = 16'd400;
    localparam logic [CMD_W-1:0] CMD_SET_MODE = 16'd176;

    localparam logic [CLS_W-1:0] CLS_PLAIN     = 2'd0;
    localparam logic [CLS_W-1:0] CLS_SET_MODE  = 2'd1;
    localparam logic [CLS_W-1:0] CLS_ARM       = 2'd2;
    localparam logic [CLS_W-1:0] CLS_LONG_MODE = 2'd3;

    localparam logic [SRC_W-1:0] SRC_QUEUE     = 2'd0;
    localparam logic [SRC_W-1:0] SRC_MANUAL    = 2'd1;
    localparam logic [SRC_W-1:0] SRC_HEARTBEAT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FRESH_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USB_LIVE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STATE_REPS   = 2'd2;

    localparam logic [WIN_W-1:0] FRESH_WINDOW_RST = 16'd300;
    localparam logic [WIN_W-1:0] USB_LIVE_RST     = 16'd2000;
    localparam logic [REP_W-1:0] STATE_REPS_RST   = 3'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_PUSH,
        ST_POP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic decode;
        logic pop;
        logic scan_run;
        logic push;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic state_cmd;
        logic plain_push;
        logic live;
        logic nonempty;
        logic scan_done;
        logic reps_zero;
        logic out_free;
    } sts_t;

    function automatic ptr_t next_ptr(input ptr_t p);
        ptr_t n;
        if (p == ptr_t'(QUEUE_SLOTS - 1))
            n = '0;
        else
            n = p + ptr_t'(1);
        return n;
    endfunction

    function automatic logic [CLS_W-1:0] class_of(input logic [ID_W-1:0] id,
                                                  input logic [CMD_W-1:0] cmd);
        logic [CLS_W-1:0] c;
        if (id == ID_SET_MODE)
            c = CLS_SET_MODE;
        else if (id == ID_LONG && cmd == CMD_ARM)
            c = CLS_ARM;
        else if (id == ID_LONG && cmd == CMD_SET_MODE)
            c = CLS_LONG_MODE;
        else
            c = CLS_PLAIN;
        return c;
    endfunction

    function automatic logic [LVL_W-1:0] queue_level(input ptr_t w, input ptr_t r);
        logic [PTR_W:0] d;
        if (w >= r)
            d = {1'b0, w} - {1'b0, r};
        else
            d = {1'b0, w} + (PTR_W+1)'(QUEUE_SLOTS) - {1'b0, r};
        return LVL_W'(d);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/uplink_slot_queue_scheduler_unit.sv =====
// top level of the uplink slot queue scheduler: stream ports, controller and datapath
// an accepted word is latched, then decoded; a live slot with a nonempty queue pops the head,
// a plain message is pushed, a state command first runs the compaction walk over the queue
// and then pushes state_repeats copies; the result register loads once the output is free
// one word at a time: s_tready high only in idle, until the result register is loaded
// reset clears pointers, drop count, times, manual latch; config takes defaults; store not reset
`default_nettype none
module uplink_slot_queue_scheduler_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [usqs_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [usqs_pkg::CFG_W-1:0]         cfg_wdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // now_ms[31:0], msg_id[55:32], command[71:56], msg_ref[87:72]
    input  wire logic [usqs_pkg::IN_DATA_W-1:0]     s_tdata,
    // operation[0]
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // sent[0], out_ref[16:1], drop_count[32:17], queue_level[37:33], zero[39:38]
    output logic [usqs_pkg::OUT_DATA_W-1:0]         m_tdata,
    // source[1:0]
    output logic [usqs_pkg::SRC_W-1:0]              m_tuser
);

    usqs_pkg::cmd_t               cmd;
    usqs_pkg::sts_t               sts;
    logic                         out_sent;
    logic [usqs_pkg::REF_W-1:0]   out_ref;
    logic [usqs_pkg::DROP_W-1:0]  out_drop;
    logic [usqs_pkg::LVL_W-1:0]   out_level;

    usqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    usqs_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_op      (s_tuser),
        .in_now     (s_tdata[31:0]),
        .in_id      (s_tdata[55:32]),
        .in_cmd     (s_tdata[71:56]),
        .in_ref     (s_tdata[87:72]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_sent   (out_sent),
        .out_source (m_tuser),
        .out_ref    (out_ref),
        .out_drop   (out_drop),
        .out_level  (out_level),
        .cmd        (cmd),
        .sts        (sts)
    );

    assign m_tdata = {2'b00, out_level, out_drop, out_ref, out_sent};

`ifndef SYNTHESIS
    a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a word is in flight");

    a_idle_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tuser == usqs_pkg::SRC_QUEUE && m_tdata[16:1] == '0))
        else $error("unsent result carries a source or handle");

    a_push_only_after_decode: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> !cmd.push && !cmd.scan_run && !cmd.out_load)
        else $error("work started before decode");
`endif

endmodule
`default_nettype wire

// ===== hdl/usqs_ctrl.sv =====
// controller state machine sequencing decode, compaction, pushes, pop and result hand-off
`default_nettype none
module usqs_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  usqs_pkg::sts_t     sts,
    output usqs_pkg::cmd_t     cmd
);

    usqs_pkg::state_t state_reg;
    usqs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= usqs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            usqs_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = usqs_pkg::ST_DECODE;
            end
            usqs_pkg::ST_DECODE:
            begin
                priority if (sts.op)
                    state_next = (sts.live && sts.nonempty) ? usqs_pkg::ST_POP
                                                            : usqs_pkg::ST_DONE;
                else if (sts.state_cmd)
                    state_next = usqs_pkg::ST_SCAN;
                else if (sts.plain_push)
                    state_next = usqs_pkg::ST_PUSH;
                else
                    state_next = usqs_pkg::ST_DONE;
            end
            usqs_pkg::ST_SCAN:
            begin
                if (sts.scan_done)
                    state_next = usqs_pkg::ST_PUSH;
            end
            usqs_pkg::ST_PUSH:
            begin
                if (sts.reps_zero)
                    state_next = usqs_pkg::ST_DONE;
            end
            usqs_pkg::ST_POP:
            begin
                state_next = usqs_pkg::ST_DONE;
            end
            usqs_pkg::ST_DONE:
            begin
                if (sts.out_free)
                    state_next = usqs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = usqs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            usqs_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            usqs_pkg::ST_DECODE:
            begin
                cmd.decode = 1'b1;
            end
            usqs_pkg::ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
            end
            usqs_pkg::ST_PUSH:
            begin
                cmd.push = !sts.reps_zero;
            end
            usqs_pkg::ST_POP:
            begin
                cmd.pop = 1'b1;
            end
            usqs_pkg::ST_DONE:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/usqs_dp.sv =====
// datapath: queue store, pointers, timers, manual latch, config registers and output register
`default_nettype none
module usqs_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [usqs_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  wire logic [usqs_pkg::CFG_W-1:0]          cfg_wdata,
    input  wire logic                                in_op,
    input  wire logic [usqs_pkg::TIME_W-1:0]         in_now,
    input  wire logic [usqs_pkg::ID_W-1:0]           in_id,
    input  wire logic [usqs_pkg::CMD_W-1:0]          in_cmd,
    input  wire logic [usqs_pkg::REF_W-1:0]          in_ref,
    input  wire logic                                m_tready,
    output logic                                     m_tvalid,
    output logic                                     out_sent,
    output logic [usqs_pkg::SRC_W-1:0]               out_source,
    output logic [usqs_pkg::REF_W-1:0]               out_ref,
    output logic [usqs_pkg::DROP_W-1:0]              out_drop,
    output logic [usqs_pkg::LVL_W-1:0]               out_level,
    input  usqs_pkg::cmd_t                           cmd,
    output usqs_pkg::sts_t                           sts
);

    // config
    logic [usqs_pkg::WIN_W-1:0] fresh_window_reg;
    logic [usqs_pkg::WIN_W-1:0] usb_live_reg;
    logic [usqs_pkg::REP_W-1:0] state_reps_reg;

    // latched input word
    logic                         op_reg;
    logic [usqs_pkg::TIME_W-1:0]  now_reg;
    logic [usqs_pkg::ID_W-1:0]    id_reg;
    logic [usqs_pkg::CMD_W-1:0]   cmd_code_reg;
    logic [usqs_pkg::REF_W-1:0]   ref_reg;

    // scheduler state
    usqs_pkg::ptr_t               wr_ptr_reg;
    usqs_pkg::ptr_t               rd_ptr_reg;
    logic [usqs_pkg::DROP_W-1:0]  dropped_reg;
    logic [usqs_pkg::REF_W-1:0]   manual_ref_reg;
    logic [usqs_pkg::TIME_W-1:0]  manual_time_reg;
    logic                         manual_valid_reg;
    logic [usqs_pkg::TIME_W-1:0]  last_host_reg;

    // compaction walk
    usqs_pkg::ptr_t               scan_r_reg;
    usqs_pkg::ptr_t               scan_w_reg;
    logic                         pend_reg;
    logic [usqs_pkg::REP_W-1:0]   reps_left_reg;

    // step result
    logic                         res_sent_reg;
    logic [usqs_pkg::SRC_W-1:0]   res_source_reg;
    logic [usqs_pkg::REF_W-1:0]   res_ref_reg;

    // output word
    logic                         m_tvalid_reg;
    logic                         o_sent_reg;
    logic [usqs_pkg::SRC_W-1:0]   o_source_reg;
    logic [usqs_pkg::REF_W-1:0]   o_ref_reg;
    logic [usqs_pkg::DROP_W-1:0]  o_drop_reg;
    logic [usqs_pkg::LVL_W-1:0]   o_level_reg;

    // queue store
    logic [usqs_pkg::ENTRY_W-1:0] mem [usqs_pkg::QUEUE_SLOTS];
    logic [usqs_pkg::ENTRY_W-1:0] rdata_reg;
    logic                         mem_we;
    usqs_pkg::ptr_t               mem_waddr;
    logic [usqs_pkg::ENTRY_W-1:0] mem_wdata;
    usqs_pkg::ptr_t               mem_raddr;

    logic [usqs_pkg::CLS_W-1:0]   cls;
    logic [usqs_pkg::TIME_W-1:0]  host_age;
    logic [usqs_pkg::TIME_W-1:0]  manual_age;
    logic                         live;
    logic                         fresh;
    logic                         nonempty;
    logic                         full;
    logic                         scan_issue;
    logic                         scan_keep;

    assign cls        = usqs_pkg::class_of(id_reg, cmd_code_reg);
    assign host_age   = now_reg - last_host_reg;
    assign manual_age = now_reg - manual_time_reg;
    assign live       = host_age < {{(usqs_pkg::TIME_W-usqs_pkg::WIN_W){1'b0}}, usb_live_reg};
    assign fresh      = manual_valid_reg &&
                        (manual_age < {{(usqs_pkg::TIME_W-usqs_pkg::WIN_W){1'b0}},
                                       fresh_window_reg});
    assign nonempty   = rd_ptr_reg != wr_ptr_reg;
    assign full       = usqs_pkg::next_ptr(wr_ptr_reg) == rd_ptr_reg;
    assign scan_issue = cmd.scan_run && (scan_r_reg != wr_ptr_reg);
    assign scan_keep  = cmd.scan_run && pend_reg &&
                        (rdata_reg[usqs_pkg::ENTRY_W-1:usqs_pkg::REF_W] != cls);

    always_comb
    begin
        mem_raddr = cmd.scan_run ? scan_r_reg : rd_ptr_reg;
        mem_we    = 1'b0;
        mem_waddr = wr_ptr_reg;
        mem_wdata = {cls, ref_reg};
        if (scan_keep)
        begin
            mem_we    = 1'b1;
            mem_waddr = scan_w_reg;
            mem_wdata = rdata_reg;
        end
        else if (cmd.push && !full)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    // payload latches
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg       <= in_op;
            now_reg      <= in_now;
            id_reg       <= in_id;
            cmd_code_reg <= in_cmd;
            ref_reg      <= in_ref;
        end
        if (cmd.out_load)
        begin
            o_sent_reg   <= res_sent_reg;
            o_source_reg <= res_source_reg;
            o_ref_reg    <= res_ref_reg;
            o_drop_reg   <= dropped_reg;
            o_level_reg  <= usqs_pkg::queue_level(wr_ptr_reg, rd_ptr_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_window_reg <= usqs_pkg::FRESH_WINDOW_RST;
            usb_live_reg     <= usqs_pkg::USB_LIVE_RST;
            state_reps_reg   <= usqs_pkg::STATE_REPS_RST;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            dropped_reg      <= '0;
            manual_ref_reg   <= '0;
            manual_time_reg  <= '0;
            manual_valid_reg <= 1'b0;
            last_host_reg    <= '0;
            scan_r_reg       <= '0;
            scan_w_reg       <= '0;
            pend_reg         <= 1'b0;
            reps_left_reg    <= '0;
            res_sent_reg     <= 1'b0;
            res_source_reg   <= '0;
            res_ref_reg      <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_addr)
                    usqs_pkg::REG_FRESH_WINDOW: fresh_window_reg <= cfg_wdata;
                    usqs_pkg::REG_USB_LIVE:     usb_live_reg     <= cfg_wdata;
                    usqs_pkg::REG_STATE_REPS:   state_reps_reg   <= cfg_wdata[usqs_pkg::REP_W-1:0];
                    default:                    ;
                endcase
            end

            if (cmd.accept)
            begin
                res_sent_reg   <= 1'b0;
                res_source_reg <= usqs_pkg::SRC_QUEUE;
                res_ref_reg    <= '0;
                if (!in_op)
                begin
                    last_host_reg <= in_now;
                    if (in_id == usqs_pkg::ID_MANUAL)
                    begin
                        manual_ref_reg   <= in_ref;
                        manual_time_reg  <= in_now;
                        manual_valid_reg <= 1'b1;
                    end
                end
            end

            if (cmd.decode)
            begin
                scan_r_reg    <= rd_ptr_reg;
                scan_w_reg    <= rd_ptr_reg;
                pend_reg      <= 1'b0;
                reps_left_reg <= (cls != usqs_pkg::CLS_PLAIN) ? state_reps_reg
                                                              : usqs_pkg::REP_W'(1);
                if (op_reg && live)
                begin
                    res_sent_reg <= 1'b1;
                    priority if (nonempty)
                    begin
                        res_source_reg <= usqs_pkg::SRC_QUEUE;
                    end
                    else if (fresh)
                    begin
                        res_source_reg <= usqs_pkg::SRC_MANUAL;
                        res_ref_reg    <= manual_ref_reg;
                    end
                    else
                    begin
                        res_source_reg <= usqs_pkg::SRC_HEARTBEAT;
                    end
                end
            end

            if (cmd.pop)
            begin
                res_ref_reg <= rdata_reg[usqs_pkg::REF_W-1:0];
                rd_ptr_reg  <= usqs_pkg::next_ptr(rd_ptr_reg);
            end

            if (cmd.scan_run)
            begin
                pend_reg <= scan_issue;
                if (scan_issue)
                    scan_r_reg <= usqs_pkg::next_ptr(scan_r_reg);
                if (scan_keep)
                    scan_w_reg <= usqs_pkg::next_ptr(scan_w_reg);
                if (!scan_issue && !pend_reg)
                    wr_ptr_reg <= scan_w_reg;
            end

            if (cmd.push)
            begin
                reps_left_reg <= reps_left_reg - usqs_pkg::REP_W'(1);
                if (full)
                    dropped_reg <= dropped_reg + usqs_pkg::DROP_W'(1);
                else
                    wr_ptr_reg <= usqs_pkg::next_ptr(wr_ptr_reg);
            end

            if (cmd.out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        sts.op         = op_reg;
        sts.state_cmd  = (id_reg != usqs_pkg::ID_MANUAL) && (cls != usqs_pkg::CLS_PLAIN);
        sts.plain_push = (id_reg != usqs_pkg::ID_MANUAL) && (id_reg != usqs_pkg::ID_HEARTBEAT);
        sts.live       = live;
        sts.nonempty   = nonempty;
        sts.scan_done  = !scan_issue && !pend_reg;
        sts.reps_zero  = reps_left_reg == '0;
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign out_sent   = o_sent_reg;
    assign out_source = o_source_reg;
    assign out_ref    = o_ref_reg;
    assign out_drop   = o_drop_reg;
    assign out_level  = o_level_reg;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the uplink slot queue scheduler: directed tests and random phases
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int HOLD_CYCLES   = 500;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 64;
    localparam int PHASE_WORDS   = 200;

    localparam logic OP_MESSAGE = 1'b0;
    localparam logic OP_SLOT    = 1'b1;

    localparam logic [usqs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [usqs_pkg::ID_W-1:0]      ID_PLAIN   = 24'd33;
    localparam logic [usqs_pkg::CMD_W-1:0]     CMD_OTHER  = 16'd177;

    localparam int OUT_REF_LSB  = 1;
    localparam int OUT_DROP_LSB = OUT_REF_LSB + usqs_pkg::REF_W;
    localparam int OUT_LVL_LSB  = OUT_DROP_LSB + usqs_pkg::DROP_W;
    localparam int OUT_PAD_LSB  = OUT_LVL_LSB + usqs_pkg::LVL_W;

    typedef struct packed {
        logic [usqs_pkg::CLS_W-1:0] cls;
        logic [usqs_pkg::REF_W-1:0] href;
    } queued_cmd_t;

    typedef struct packed {
        logic                        sent;
        logic [usqs_pkg::SRC_W-1:0]  src;
        logic [usqs_pkg::REF_W-1:0]  oref;
        logic [usqs_pkg::DROP_W-1:0] drops;
        logic [usqs_pkg::LVL_W-1:0]  lvl;
    } uplink_result_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [usqs_pkg::CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [usqs_pkg::CFG_W-1:0]      cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [usqs_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [usqs_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [usqs_pkg::SRC_W-1:0]      m_tuser;

    // scheduler state as predicted
    queued_cmd_t                   queued_cmds[$];
    logic [usqs_pkg::DROP_W-1:0]   drop_tally   = '0;
    logic [usqs_pkg::REF_W-1:0]    manual_href  = '0;
    logic [usqs_pkg::TIME_W-1:0]   manual_ms    = '0;
    logic                          manual_held  = 1'b0;
    logic [usqs_pkg::TIME_W-1:0]   host_seen_ms = '0;
    logic [usqs_pkg::WIN_W-1:0]    fresh_cfg    = usqs_pkg::FRESH_WINDOW_RST;
    logic [usqs_pkg::WIN_W-1:0]    live_cfg     = usqs_pkg::USB_LIVE_RST;
    logic [usqs_pkg::REP_W-1:0]    repeats_cfg  = usqs_pkg::STATE_REPS_RST;

    uplink_result_t      uplink_results_due[$];
    int                  mismatch_count = 0;

    logic [usqs_pkg::TIME_W-1:0] now_base = '0;
    int                  burst_left = 0;
    int                  max_gap    = 6;

    int                  hold_asks   = 0;
    int                  hold_seen   = 0;
    int                  hold_left   = 0;
    logic [7:0]          rx_pattern  = 8'hFF;
    logic [5:0]          rx_tick     = '0;
    int                  quiet_cycles = 0;

    uplink_slot_queue_scheduler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic uplink_result_t next_uplink_result(
        input logic                          op,
        input logic [usqs_pkg::TIME_W-1:0]   now,
        input logic [usqs_pkg::ID_W-1:0]     id,
        input logic [usqs_pkg::CMD_W-1:0]    cmd,
        input logic [usqs_pkg::REF_W-1:0]    href);
        uplink_result_t             res;
        queued_cmd_t                ent;
        logic [usqs_pkg::CLS_W-1:0] cls;
        int                         copies;
        int                         keep;
        res = '0;
        if (op == OP_MESSAGE)
        begin
            host_seen_ms = now;
            if (id == usqs_pkg::ID_MANUAL)
            begin
                manual_href = href;
                manual_ms   = now;
                manual_held = 1'b1;
            end
            else if (id != usqs_pkg::ID_HEARTBEAT)
            begin
                cls    = usqs_pkg::CLS_PLAIN;
                copies = 1;
                if (id == usqs_pkg::ID_SET_MODE)
                    cls = usqs_pkg::CLS_SET_MODE;
                else if (id == usqs_pkg::ID_LONG && cmd == usqs_pkg::CMD_ARM)
                    cls = usqs_pkg::CLS_ARM;
                else if (id == usqs_pkg::ID_LONG && cmd == usqs_pkg::CMD_SET_MODE)
                    cls = usqs_pkg::CLS_LONG_MODE;
                if (cls != usqs_pkg::CLS_PLAIN)
                begin
                    // drop older entries of the same class, order of the rest kept
                    copies = int'(repeats_cfg);
                    keep   = 0;
                    for (int i = 0; i < queued_cmds.size(); i++)
                    begin
                        if (queued_cmds[i].cls != cls)
                        begin
                            queued_cmds[keep] = queued_cmds[i];
                            keep++;
                        end
                    end
                    while (queued_cmds.size() > keep)
                        void'(queued_cmds.pop_back());
                end
                ent.cls  = cls;
                ent.href = href;
                for (int i = 0; i < copies; i++)
                begin
                    if (queued_cmds.size() == usqs_pkg::QUEUE_SLOTS - 1)
                        drop_tally++;
                    else
                        queued_cmds.push_back(ent);
                end
            end
        end
        else if (now - host_seen_ms < usqs_pkg::TIME_W'(live_cfg))
        begin
            res.sent = 1'b1;
            if (queued_cmds.size() != 0)
            begin
                ent      = queued_cmds.pop_front();
                res.src  = usqs_pkg::SRC_QUEUE;
                res.oref = ent.href;
            end
            else if (manual_held && now - manual_ms < usqs_pkg::TIME_W'(fresh_cfg))
            begin
                res.src  = usqs_pkg::SRC_MANUAL;
                res.oref = manual_href;
            end
            else
                res.src = usqs_pkg::SRC_HEARTBEAT;
        end
        res.drops = drop_tally;
        res.lvl   = usqs_pkg::LVL_W'(queued_cmds.size());
        return res;
    endfunction

    task automatic report_result(input string what, input uplink_result_t want,
                                 input uplink_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: sent %0d/%0d source %0d/%0d ref %h/%h drops %0d/%0d level %0d/%0d",
                     $time, what, want.sent, got.sent, want.src, got.src, want.oref, got.oref,
                     want.drops, got.drops, want.lvl, got.lvl);
    endtask

    task automatic send_word(input logic op, input logic [usqs_pkg::TIME_W-1:0] now,
                             input logic [usqs_pkg::ID_W-1:0] id,
                             input logic [usqs_pkg::CMD_W-1:0] cmd,
                             input logic [usqs_pkg::REF_W-1:0] href);
        int gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, max_gap);
            burst_left = $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {href, cmd, id, now};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        uplink_results_due.push_back(next_uplink_result(op, now, id, cmd, href));
        burst_left--;
    endtask

    task automatic drain_and_idle(input int extra);
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (uplink_results_due.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [usqs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [usqs_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            usqs_pkg::REG_FRESH_WINDOW: fresh_cfg   = val;
            usqs_pkg::REG_USB_LIVE:     live_cfg    = val;
            usqs_pkg::REG_STATE_REPS:   repeats_cfg = val[usqs_pkg::REP_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_registers(input logic [usqs_pkg::CFG_W-1:0] fresh,
                                 input logic [usqs_pkg::CFG_W-1:0] live,
                                 input logic [usqs_pkg::CFG_W-1:0] reps);
        drain_and_idle(SETTLE_CYCLES);
        write_reg(usqs_pkg::REG_FRESH_WINDOW, fresh);
        write_reg(usqs_pkg::REG_USB_LIVE, live);
        write_reg(usqs_pkg::REG_STATE_REPS, reps);
    endtask

    task automatic fill_ring();
        while (queued_cmds.size() < usqs_pkg::QUEUE_SLOTS - 1)
            send_word(OP_MESSAGE, now_base, ID_PLAIN, usqs_pkg::CMD_W'($urandom),
                      usqs_pkg::REF_W'($urandom));
    endtask

    task automatic send_random_item(input int slot_pct);
        logic                       op;
        logic [usqs_pkg::ID_W-1:0]  id;
        logic [usqs_pkg::CMD_W-1:0] cmd;
        int                         pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            now_base += $urandom_range(0, 40);
        else if (pick < 90)
            now_base += $urandom_range(0, 3000);
        else if (pick < 97)
            now_base += $urandom_range(1000, 70000);
        else
            now_base = $urandom;
        op  = ($urandom_range(0, 99) < slot_pct) ? OP_SLOT : OP_MESSAGE;
        cmd = usqs_pkg::CMD_W'($urandom);
        case ($urandom_range(0, 9))
            0: id = usqs_pkg::ID_HEARTBEAT;
            1, 2: id = usqs_pkg::ID_MANUAL;
            3: id = usqs_pkg::ID_SET_MODE;
            4:
            begin
                id  = usqs_pkg::ID_LONG;
                cmd = usqs_pkg::CMD_ARM;
            end
            5:
            begin
                id  = usqs_pkg::ID_LONG;
                cmd = usqs_pkg::CMD_SET_MODE;
            end
            6: id = usqs_pkg::ID_LONG;
            7: id = ID_PLAIN;
            default: id = usqs_pkg::ID_W'($urandom);
        endcase
        send_word(op, now_base, id, cmd, usqs_pkg::REF_W'($urandom));
    endtask

    task automatic test_reset_window();
        send_word(OP_SLOT, 32'd0, usqs_pkg::ID_HEARTBEAT, '0, '0);
        send_word(OP_SLOT, 32'd1999, usqs_pkg::ID_HEARTBEAT, '0, '0);
        send_word(OP_SLOT, 32'd2000, usqs_pkg::ID_HEARTBEAT, '0, '0);
        send_word(OP_SLOT, 32'hFFFF_FFFF, usqs_pkg::ID_HEARTBEAT, '0, '0);
    endtask

    task automatic test_message_kinds();
        send_word(OP_MESSAGE, 32'd10000, usqs_pkg::ID_HEARTBEAT, 16'hFFFF, 16'hFFFF);
        send_word(OP_SLOT, 32'd11000, usqs_pkg::ID_HEARTBEAT, '0, '0);
        send_word(OP_MESSAGE, 32'd12000, usqs_pkg::ID_MANUAL, '0, 16'hFFFF);
        send_word(OP_SLOT, 32'd12299, usqs_pkg::ID_HEARTBEAT, '0, '0);
        send_word(OP_SLOT, 32'd12300, usqs_pkg::ID_HEARTBEAT, '0, '0);
        send_word(OP_MESSAGE, 32'd13000, 24'hFF_FFFF, 16'hFFFF, 16'h0001);
        send_word(OP_MESSAGE, 32'd13001, usqs_pkg::ID_LONG, CMD_OTHER, 16'h0002);
        send_word(OP_MESSAGE, 32'd13002, usqs_pkg::ID_SET_MODE, '0, 16'h0010);
        send_word(OP_MESSAGE, 32'd13003, usqs_pkg::ID_LONG, usqs_pkg::CMD_ARM, 16'h0020);
        send_word(OP_MESSAGE, 32'd13004, usqs_pkg::ID_LONG, usqs_pkg::CMD_SET_MODE, 16'h0030);
        send_word(OP_MESSAGE, 32'd13005, usqs_pkg::ID_SET_MODE, '0, 16'h0011);
        repeat (4) send_word(OP_SLOT, 32'd13100, usqs_pkg::ID_HEARTBEAT, '0, '0);
        // time wraps between the message and the slot
        send_word(OP_MESSAGE, 32'hFFFF_FF00, ID_PLAIN, '0, 16'h8000);
        send_word(OP_SLOT, 32'h0000_0010, usqs_pkg::ID_HEARTBEAT, '0, '0);
        now_base = 32'h0000_0010;
    endtask

    task automatic test_register_extremes();
        set_registers(16'hFFFF, 16'hFFFF, 16'd0);
        write_reg(REG_UNUSED, 16'hFFFF);
        // zero repeats still clear the class
        send_word(OP_MESSAGE, now_base, usqs_pkg::ID_LONG, usqs_pkg::CMD_ARM, 16'h0A00);
        send_word(OP_MESSAGE, now_base, usqs_pkg::ID_SET_MODE, '0, 16'h0B00);
        drain_and_idle(SETTLE_CYCLES);
        write_reg(usqs_pkg::REG_STATE_REPS, 16'hFFFD);
        send_word(OP_MESSAGE, now_base, usqs_pkg::ID_LONG, usqs_pkg::CMD_SET_MODE, 16'h0C00);
        set_registers(16'd0, 16'd0, 16'd7);
        send_word(OP_SLOT, now_base, usqs_pkg::ID_HEARTBEAT, '0, '0);
        send_word(OP_MESSAGE, now_base, usqs_pkg::ID_LONG, usqs_pkg::CMD_SET_MODE, 16'h0D00);
    endtask

    task automatic test_ring_overflow();
        set_registers(usqs_pkg::FRESH_WINDOW_RST, usqs_pkg::USB_LIVE_RST, 16'd7);
        fill_ring();
        send_word(OP_MESSAGE, now_base, ID_PLAIN, '0, 16'h1234);
        send_word(OP_MESSAGE, now_base, usqs_pkg::ID_SET_MODE, '0, 16'h2345);
        send_word(OP_MESSAGE, now_base, usqs_pkg::ID_LONG, usqs_pkg::CMD_ARM, 16'h3456);
        send_word(OP_SLOT, now_base, usqs_pkg::ID_HEARTBEAT, '0, '0);
    endtask

    task automatic test_random_phases();
        int slot_pct;
        for (int phase = 0; phase < 7; phase++)
        begin
            slot_pct = 40;
            case (phase)
                0: set_registers(usqs_pkg::FRESH_WINDOW_RST, usqs_pkg::USB_LIVE_RST,
                                 usqs_pkg::CFG_W'(usqs_pkg::STATE_REPS_RST));
                1: set_registers(16'hFFFF, 16'hFFFF, 16'd7);
                2:
                begin
                    set_registers(16'd0, 16'hFFFF, 16'd0);
                    slot_pct = 60;
                end
                3: set_registers(usqs_pkg::CFG_W'($urandom), usqs_pkg::CFG_W'($urandom),
                                 usqs_pkg::CFG_W'($urandom_range(0, 7)));
                4:
                begin
                    set_registers(16'hFFFF, 16'd0, 16'd4);
                    slot_pct = 25;
                end
                5: set_registers(usqs_pkg::CFG_W'($urandom_range(0, 600)),
                                 usqs_pkg::CFG_W'($urandom_range(0, 4000)),
                                 usqs_pkg::CFG_W'($urandom_range(1, 4)));
                default:
                begin
                    set_registers(usqs_pkg::CFG_W'($urandom_range(0, 1000)),
                                  usqs_pkg::CFG_W'($urandom_range(500, 3000)),
                                  usqs_pkg::CFG_W'($urandom_range(1, 4)));
                    slot_pct = 50;
                end
            endcase
            if (phase == 1)
            begin
                // long receiver hold while words keep coming
                max_gap = 0;
                hold_asks++;
            end
            for (int n = 0; n < PHASE_WORDS; n++)
                send_random_item(slot_pct);
            max_gap = 6;
        end
    endtask

    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1'b1;
        if (hold_seen != hold_asks)
        begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            if (rx_tick == '0)
                rx_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
            else
                rx_pattern <= {rx_pattern[0], rx_pattern[7:1]};
            m_tready <= rx_pattern[0];
        end
    end

    always @(posedge clk)
    begin
        uplink_result_t want;
        uplink_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.sent  = m_tdata[0];
            got.src   = m_tuser;
            got.oref  = m_tdata[OUT_REF_LSB +: usqs_pkg::REF_W];
            got.drops = m_tdata[OUT_DROP_LSB +: usqs_pkg::DROP_W];
            got.lvl   = m_tdata[OUT_LVL_LSB +: usqs_pkg::LVL_W];
            if (uplink_results_due.size() == 0)
                report_result("unexpected word", '0, got);
            else
            begin
                want = uplink_results_due.pop_front();
                if (got !== want || m_tdata[usqs_pkg::OUT_DATA_W-1:OUT_PAD_LSB] !== '0)
                    report_result("mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("** uplink_slot_queue_scheduler_unit: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_window();
        test_message_kinds();
        test_register_extremes();
        test_ring_overflow();
        test_random_phases();
        drain_and_idle(END_CYCLES);
        if (mismatch_count == 0 && uplink_results_due.size() == 0)
            $display("** uplink_slot_queue_scheduler_unit: PASSED **");
        else
            $display("** uplink_slot_queue_scheduler_unit: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/usqs_pkg.sv
hdl/usqs_ctrl.sv
hdl/usqs_dp.sv
hdl/uplink_slot_queue_scheduler_unit.sv
tb/tb_top.sv
